[hdl/cvm_pkg.sv]
`default_nettype none

package cvm_pkg;

    // default configuration of the sine table and angle scale
    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int ANGLE_BITS_DEF       = 16;

    // field widths
    localparam int POS_W   = 32;
    localparam int ANGLE_W = 16;
    localparam int ENTRY_W = 17;

    // fixed point constants
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    // row codes
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    // rotation entry, range -1.0 .. 1.0 in signed Q2.16
    typedef logic signed [17:0] t_trig;

    // load strobes for the two trig stages
    typedef struct packed {
        logic ld1;
        logic ld2;
    } t_stage_en;

    // quarter-wave sine entry from a Taylor series, evaluated at elaboration
    function automatic logic [ENTRY_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic signed [63:0] r;
        term = x;
        acc  = $signed(x);
        // x^3 / 3!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd6;
        acc  = acc - $signed(term);
        // x^5 / 5!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd20;
        acc  = acc + $signed(term);
        // x^7 / 7!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd42;
        acc  = acc - $signed(term);
        // x^9 / 9!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd72;
        acc  = acc + $signed(term);
        // x^11 / 11!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd110;
        acc  = acc - $signed(term);
        // x^13 / 13!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd156;
        acc  = acc + $signed(term);
        // x^15 / 15!
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd210;
        acc  = acc - $signed(term);
        // clamp, round half up to Q16, clamp to one
        if (acc < 0) begin
            acc = 64'sd0;
        end
        r = (acc + 64'sd8192) >>> 14;
        if (r > 64'sd65536) begin
            r = 64'sd65536;
        end
        return r[ENTRY_W-1:0];
    endfunction

    // product of two Q2.16 entries, rounded half up
    function automatic t_trig round_prod(input logic signed [35:0] p);
        logic signed [35:0] t;
        t = p + 36'sd32768;
        return t[33:16];
    endfunction

endpackage

`default_nettype wire

[hdl/cvm_if.sv]
`default_nettype none

// pose channel
interface cvm_pose_if
    import cvm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic        [ANGLE_W-1:0] yaw_angle;
    logic        [ANGLE_W-1:0] pitch_angle;

    modport source (output valid, pos_x, pos_y, pos_z, yaw_angle, pitch_angle,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, yaw_angle, pitch_angle,
                    output ready);
endinterface

// matrix row channel
interface cvm_row_if
    import cvm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic        [1:0]       row_index;
    logic signed [POS_W-1:0] col_zero;
    logic signed [POS_W-1:0] col_one;
    logic signed [POS_W-1:0] col_two;
    logic signed [POS_W-1:0] col_three;
    logic                    last_row;

    modport source (output valid, row_index, col_zero, col_one, col_two, col_three,
                    last_row, input ready);
    modport sink   (input valid, row_index, col_zero, col_one, col_two, col_three,
                    last_row, output ready);
endinterface

`default_nettype wire

[hdl/camera_view_matrix_top.sv]
// channel   dir  handshake     payload
// i_pose    in   valid/ready   pos_x, pos_y, pos_z, yaw_angle, pitch_angle
// o_row     out  valid/ready   row_index, col_zero..col_three, last_row
//
// a pose enters in any cycle the pipe has room; it passes through six pipeline stages,
// the row hold register and the output register, and its rows 0 to 3 leave on
// consecutive beats
// sustained pose rate is set by the one-row-per-beat output, four rows per pose
// synchronous active-low reset clears the valid bits, the row counter and the output valid
// and holds i_pose ready low
// a stall on o_row backs up stage by stage; nothing is dropped or repeated
`default_nettype none

module camera_view_matrix_top
    import cvm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cvm_pose_if.sink   i_pose,
    cvm_row_if.source  o_row
);

    localparam int NSTG = 6;

    // pipeline handshake
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   stg_rdy;
    logic            ser_ready;
    t_stage_en       trig_en;

    always_comb begin
        stg_rdy[NSTG] = ser_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_v[k] || stg_rdy[k+1];
        end
    end

    assign i_pose.ready = stg_rdy[0] && i_rst_n;
    assign trig_en.ld1  = stg_rdy[0];
    assign trig_en.ld2  = stg_rdy[1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_v[0] <= i_pose.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stages 1 and 2: sine and cosine of both angles
    t_trig yaw_sin, yaw_cos, pit_sin, pit_cos;

    cvm_sincos #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ANGLE_BITS       (ANGLE_BITS)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_en    (trig_en),
        .i_angle (i_pose.yaw_angle),
        .o_sin   (yaw_sin),
        .o_cos   (yaw_cos)
    );

    cvm_sincos #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ANGLE_BITS       (ANGLE_BITS)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_en    (trig_en),
        .i_angle (i_pose.pitch_angle),
        .o_sin   (pit_sin),
        .o_cos   (pit_cos)
    );

    // position carried alongside the trig stages
    logic signed [POS_W-1:0] r1_pos [3];
    logic signed [POS_W-1:0] r2_pos [3];
    logic signed [POS_W-1:0] r3_pos [3];

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r1_pos[0] <= i_pose.pos_x;
            r1_pos[1] <= i_pose.pos_y;
            r1_pos[2] <= i_pose.pos_z;
        end
        if (stg_rdy[1]) begin
            r2_pos <= r1_pos;
        end
        if (stg_rdy[2]) begin
            r3_pos <= r2_pos;
        end
    end

    // stage 3: rotation matrix
    t_trig neg_s, neg_sp;
    t_trig r3_m [3][3];

    assign neg_s  = -yaw_sin;
    assign neg_sp = -pit_sin;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r3_m[0][0] <= yaw_cos;
            r3_m[0][1] <= yaw_sin;
            r3_m[0][2] <= '0;
            r3_m[1][0] <= round_prod(36'(pit_cos) * 36'(neg_s));
            r3_m[1][1] <= round_prod(36'(pit_cos) * 36'(yaw_cos));
            r3_m[1][2] <= pit_sin;
            r3_m[2][0] <= round_prod(36'(neg_sp) * 36'(neg_s));
            r3_m[2][1] <= round_prod(36'(neg_sp) * 36'(yaw_cos));
            r3_m[2][2] <= pit_cos;
        end
    end

    // stage 4: entry times position products
    logic signed [49:0] r4_p [3][3];
    t_trig              r4_m [3][3];

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r4_m <= r3_m;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_p[r][k] <= 50'(r3_m[r][k]) * 50'(r3_pos[k]);
                end
            end
        end
    end

    // stage 5: dot products
    logic signed [50:0] r5_sum [3];
    t_trig              r5_m   [3][3];

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r5_m <= r4_m;
            for (int r = 0; r < 3; r++) begin
                r5_sum[r] <= 51'(r4_p[r][0]) + 51'(r4_p[r][1]) + 51'(r4_p[r][2]);
            end
        end
    end

    // stage 6: negate, round half up, saturate
    logic signed [50:0]      neg_rnd [3];
    logic signed [34:0]      tr_q16  [3];
    logic signed [POS_W-1:0] n6_c3   [3];
    logic signed [POS_W-1:0] r6_c3   [3];
    t_trig                   r6_m    [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            neg_rnd[r] = ~r5_sum[r] + 51'sd32769;
            tr_q16[r]  = neg_rnd[r][50:16];
            if (tr_q16[r] > 35'sd2147483647) begin
                n6_c3[r] = 32'sh7FFF_FFFF;
            end else if (tr_q16[r] < -35'sd2147483648) begin
                n6_c3[r] = 32'sh8000_0000;
            end else begin
                n6_c3[r] = tr_q16[r][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[5]) begin
            r6_m  <= r5_m;
            r6_c3 <= n6_c3;
        end
    end

    // row serializer with output register
    logic                    r_sv;
    logic [1:0]              r_row;
    t_trig                   r_hold_m  [3][3];
    logic signed [POS_W-1:0] r_hold_c3 [3];
    logic                    r_ov;
    logic [1:0]              r_o_row;
    logic signed [POS_W-1:0] r_o_c0, r_o_c1, r_o_c2, r_o_c3;
    logic                    r_o_last;
    logic                    out_load;

    assign out_load  = !r_ov || o_row.ready;
    assign ser_ready = !r_sv || (out_load && r_row == ROW_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_row <= ROW_FIRST;
            r_ov  <= 1'b0;
        end else begin
            if (ser_ready) begin
                r_sv  <= r_v[NSTG-1];
                r_row <= ROW_FIRST;
            end else if (out_load) begin
                r_row <= r_row + 2'd1;
            end
            if (out_load) begin
                r_ov <= r_sv;
            end
        end
    end

    // matrix hold and row payload
    always_ff @(posedge i_clk) begin
        if (ser_ready) begin
            r_hold_m  <= r6_m;
            r_hold_c3 <= r6_c3;
        end
        if (out_load && r_sv) begin
            r_o_row <= r_row;
            if (r_row == ROW_LAST) begin
                r_o_c0   <= '0;
                r_o_c1   <= '0;
                r_o_c2   <= '0;
                r_o_c3   <= ONE_Q16;
                r_o_last <= 1'b1;
            end else begin
                r_o_c0   <= POS_W'(r_hold_m[r_row][0]);
                r_o_c1   <= POS_W'(r_hold_m[r_row][1]);
                r_o_c2   <= POS_W'(r_hold_m[r_row][2]);
                r_o_c3   <= r_hold_c3[r_row];
                r_o_last <= 1'b0;
            end
        end
    end

    assign o_row.valid     = r_ov;
    assign o_row.row_index = r_o_row;
    assign o_row.col_zero  = r_o_c0;
    assign o_row.col_one   = r_o_c1;
    assign o_row.col_two   = r_o_c2;
    assign o_row.col_three = r_o_c3;
    assign o_row.last_row  = r_o_last;

`ifndef SYNTHESIS
    // an accepted pose occupies the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pose.valid && i_pose.ready) |=> r_v[0])
        else $error("accepted pose missing from first stage");

    // the end flag marks exactly the fourth row
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row.valid |-> (o_row.last_row == (o_row.row_index == ROW_LAST)))
        else $error("last_row does not match row_index");

    // a matrix in the serializer is not dropped before its last row
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && r_row != ROW_LAST) |=> r_sv)
        else $error("serializer dropped a matrix mid-way");
`endif

endmodule

`default_nettype wire

[hdl/cvm_sincos.sv]
`default_nettype none

module cvm_sincos
    import cvm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire t_stage_en          i_en,
    input  wire logic [ANGLE_W-1:0] i_angle,
    output t_trig                   o_sin,
    output t_trig                   o_cos
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EXT_W = ANGLE_BITS + ANGLE_W;
    localparam int P_W   = ANGLE_BITS - 2;
    localparam int PR_W  = P_W + IDX_W + 1;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << P_W;
    localparam logic [PR_W-1:0]       HALF_Q  = PR_W'(1) << (P_W - 1);
    localparam logic [PR_W-1:0]       DEPTH_P = PR_W'(SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0]      DEPTH_I = IDX_W'(SINE_TABLE_DEPTH);

    // constant quarter-wave table
    logic [ENTRY_W-1:0] tab_q16 [SINE_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_tab
        localparam logic [63:0] X_Q30 = (PI_HALF_Q30 * 64'(gi)) / SINE_TABLE_DEPTH;
        assign tab_q16[gi] = sine_entry(X_Q30);
    end

    // angle masked to the turn, cosine lane shifted by a quarter
    logic [EXT_W-1:0]      ang_ext;
    logic [ANGLE_BITS-1:0] lane_ang [2];
    logic [IDX_W-1:0]      n_idx    [2];
    logic                  n_neg    [2];
    logic [PR_W-1:0]       lane_sum [2];
    logic [IDX_W-1:0]      lane_raw [2];
    logic [IDX_W-1:0]      r_idx    [2];
    logic                  r_neg    [2];
    t_trig                 r_val    [2];

    assign ang_ext     = EXT_W'(i_angle);
    assign lane_ang[0] = ang_ext[ANGLE_BITS-1:0];
    assign lane_ang[1] = ang_ext[ANGLE_BITS-1:0] + QUARTER;

    // table index from the position within the quadrant, mirrored on odd quadrants
    always_comb begin
        for (int ln = 0; ln < 2; ln++) begin
            lane_sum[ln] = PR_W'(lane_ang[ln][P_W-1:0]) * DEPTH_P + HALF_Q;
            lane_raw[ln] = lane_sum[ln][P_W +: IDX_W];
            if (lane_raw[ln] > DEPTH_I) begin
                lane_raw[ln] = DEPTH_I;
            end
            n_idx[ln] = lane_ang[ln][ANGLE_BITS-2] ? DEPTH_I - lane_raw[ln] : lane_raw[ln];
            n_neg[ln] = lane_ang[ln][ANGLE_BITS-1];
        end
    end

    // stage 1: index registers
    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_idx <= n_idx;
            r_neg <= n_neg;
        end
    end

    // stage 2: table read and sign
    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            for (int ln = 0; ln < 2; ln++) begin
                r_val[ln] <= r_neg[ln] ? -t_trig'({1'b0, tab_q16[r_idx[ln]]})
                                       :  t_trig'({1'b0, tab_q16[r_idx[ln]]});
            end
        end
    end

    assign o_sin = r_val[0];
    assign o_cos = r_val[1];

endmodule

`default_nettype wire

[sim/camera_view_matrix_top_test.sv]
`timescale 1ns / 1ps

module camera_view_matrix_top_test;
    import cvm_pkg::*;

    localparam int LUT_DEPTH   = 256;
    localparam int ANGLE_SPAN  = 16;
    localparam int QUARTER     = 1 << (ANGLE_SPAN - 2);
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 20;

    // one expected matrix row
    typedef struct {
        logic [1:0]              row_index;
        logic signed [POS_W-1:0] col_zero;
        logic signed [POS_W-1:0] col_one;
        logic signed [POS_W-1:0] col_two;
        logic signed [POS_W-1:0] col_three;
        logic                    last_row;
    } t_view_row;

    logic i_clk;
    logic i_rst_n;

    cvm_pose_if pose_bus ();
    cvm_row_if  row_bus ();

    camera_view_matrix_top #(
        .SINE_TABLE_DEPTH (LUT_DEPTH),
        .ANGLE_BITS       (ANGLE_SPAN)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_bus),
        .o_row   (row_bus)
    );

    longint      sine_lut [0:LUT_DEPTH];
    t_view_row   view_rows_due [$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    bit          idle_on;
    int unsigned row_hold_len;
    bit          row_hold_active;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // quarter-wave sine table, Taylor series to x^15 in unsigned Q30, rounded to Q16
    function automatic void build_sine_lut();
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint          r;
        int              i;
        int              k;
        for (i = 0; i <= LUT_DEPTH; i++) begin
            x    = (64'd1686629713 * longint'(i)) / longint'(LUT_DEPTH);
            term = x;
            acc  = $signed(x);
            for (k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            r = (acc + 8192) >>> 14;
            if (r > 65536) begin
                r = 65536;
            end
            sine_lut[i] = r;
        end
    endfunction

    // table lookup by quadrant, nearest entry
    function automatic longint lut_sine(input int unsigned angle);
        int unsigned a;
        int unsigned quad;
        int unsigned p;
        int unsigned idx;
        a    = angle & ((1 << ANGLE_SPAN) - 1);
        quad = a >> (ANGLE_SPAN - 2);
        p    = a & (QUARTER - 1);
        idx  = (p * LUT_DEPTH + QUARTER / 2) / QUARTER;
        if (idx > LUT_DEPTH) begin
            idx = LUT_DEPTH;
        end
        if (quad[0]) begin
            idx = LUT_DEPTH - idx;
        end
        return quad[1] ? -sine_lut[idx] : sine_lut[idx];
    endfunction

    // floor((v + 2^15) / 2^16)
    function automatic longint rounded_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    // minus the dot product with the position, saturated to Q16.16
    function automatic longint translation_entry(input longint r0, r1, r2, x, y, z);
        longint t;
        t = rounded_q16(-(r0 * x + r1 * y + r2 * z));
        if (t > 64'sd2147483647) begin
            t = 64'sd2147483647;
        end
        if (t < -64'sd2147483648) begin
            t = -64'sd2147483648;
        end
        return t;
    endfunction

    // work out the four rows of one pose and queue them
    function automatic void queue_view_rows(input logic signed [POS_W-1:0] px, py, pz,
                                            input logic [ANGLE_W-1:0] yaw, pitch);
        longint    x, y, z, s, c, sp, cp;
        longint    m [0:2][0:2];
        t_view_row row;
        int        r;
        x  = px;
        y  = py;
        z  = pz;
        s  = -lut_sine(yaw);
        c  = lut_sine(yaw + QUARTER);
        sp = -lut_sine(pitch);
        cp = lut_sine(pitch + QUARTER);
        m[0][0] = c;
        m[0][1] = -s;
        m[0][2] = 0;
        m[1][0] = rounded_q16(cp * s);
        m[1][1] = rounded_q16(cp * c);
        m[1][2] = -sp;
        m[2][0] = rounded_q16(sp * s);
        m[2][1] = rounded_q16(sp * c);
        m[2][2] = cp;
        for (r = 0; r < 3; r++) begin
            row.row_index = 2'(r);
            row.col_zero  = m[r][0][POS_W-1:0];
            row.col_one   = m[r][1][POS_W-1:0];
            row.col_two   = m[r][2][POS_W-1:0];
            row.col_three = POS_W'(translation_entry(m[r][0], m[r][1], m[r][2], x, y, z));
            row.last_row  = 1'b0;
            view_rows_due.push_back(row);
        end
        row.row_index = ROW_LAST;
        row.col_zero  = '0;
        row.col_one   = '0;
        row.col_two   = '0;
        row.col_three = ONE_Q16;
        row.last_row  = 1'b1;
        view_rows_due.push_back(row);
    endfunction

    function automatic void check_field(input string what, input logic [31:0] due, got);
        if (got !== due) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, $signed(due), $signed(got));
            mismatch_count++;
        end
    endfunction

    // scoreboard: predict on every accepted pose, check every accepted row
    always @(posedge i_clk) begin
        if (pose_bus.valid === 1'b1 && pose_bus.ready === 1'b1) begin
            queue_view_rows(pose_bus.pos_x, pose_bus.pos_y, pose_bus.pos_z,
                            pose_bus.yaw_angle, pose_bus.pitch_angle);
        end
        if (row_bus.valid === 1'b1 && row_bus.ready === 1'b1) begin
            if (view_rows_due.size() == 0) begin
                $display("%0t: row beat with no pose pending, row_index %0d",
                         $time, row_bus.row_index);
                mismatch_count++;
            end else begin
                t_view_row due;
                due = view_rows_due.pop_front();
                check_field("row_index", 32'(due.row_index), 32'(row_bus.row_index));
                check_field("col_zero",  due.col_zero,  row_bus.col_zero);
                check_field("col_one",   due.col_one,   row_bus.col_one);
                check_field("col_two",   due.col_two,   row_bus.col_two);
                check_field("col_three", due.col_three, row_bus.col_three);
                check_field("last_row",  32'(due.last_row), 32'(row_bus.last_row));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((pose_bus.valid === 1'b1 && pose_bus.ready === 1'b1) ||
            (row_bus.valid === 1'b1 && row_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("camera_view_matrix_top_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // row receiver: random stalls, long holds on request
    initial begin : row_receiver
        int unsigned span;
        row_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (row_hold_len != 0) begin
                span            = row_hold_len;
                row_hold_len    = 0;
                row_hold_active = 1'b1;
                row_bus.ready <= 1'b0;
                repeat (span) @(posedge i_clk);
                row_hold_active = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                row_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                row_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // offer one pose, return at the edge where it is taken; valid stays high
    task automatic send_pose(input logic signed [POS_W-1:0] x, y, z,
                             input logic [ANGLE_W-1:0] yaw, pitch);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (gap != 0) begin
            pose_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pose_bus.valid       <= 1'b1;
        pose_bus.pos_x       <= x;
        pose_bus.pos_y       <= y;
        pose_bus.pos_z       <= z;
        pose_bus.yaw_angle   <= yaw;
        pose_bus.pitch_angle <= pitch;
        @(posedge i_clk);
        while (pose_bus.ready !== 1'b1) @(posedge i_clk);
    endtask

    function automatic logic [ANGLE_W-1:0] random_angle();
        // bias toward quadrant edges now and then
        if ($urandom_range(0, 4) == 0) begin
            return ANGLE_W'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 2) - 1);
        end
        return ANGLE_W'($urandom);
    endfunction

    function automatic logic signed [POS_W-1:0] random_position();
        if ($urandom_range(0, 2) == 0) begin
            return $urandom;
        end
        return POS_W'($signed($urandom_range(0, 2097151)) - 1048576);
    endfunction

    task automatic send_random_pose();
        send_pose(random_position(), random_position(), random_position(),
                  random_angle(), random_angle());
    endtask

    task automatic wait_drained();
        while (view_rows_due.size() != 0) @(posedge i_clk);
    endtask

    // quadrant edges and rounding into the last table entry
    task automatic test_angle_extremes();
        logic [ANGLE_W-1:0] angles [0:11];
        int                 i;
        angles = '{16'd0, 16'd1, 16'd8191, 16'd8192, 16'd16383, 16'd16384,
                   16'd16385, 16'd24576, 16'd32767, 16'd32768, 16'd49152, 16'd65535};
        for (i = 0; i < 12; i++) begin
            send_pose(32'sh0001_2345, -32'sh0003_8000, 32'sh0000_4000,
                      angles[i], angles[11 - i]);
        end
    endtask

    // extreme positions, translation at and past the Q16.16 bounds
    task automatic test_translation_saturation();
        localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] PMIN = 32'sh8000_0000;
        send_pose(PMIN, PMIN, PMIN, 16'd0, 16'd0);
        send_pose(PMAX, PMAX, PMAX, 16'd0, 16'd0);
        send_pose(32'sd0, 32'sd0, 32'sd0, 16'd12345, 16'd54321);
        send_pose(PMAX, PMAX, PMAX, 16'd8192, 16'd8192);
        send_pose(PMIN, PMIN, PMIN, 16'd8192, 16'd57344);
        send_pose(PMAX, PMIN, PMAX, 16'd40960, 16'd24576);
        send_pose(PMIN, PMAX, PMIN, 16'd32768, 16'd32768);
        send_pose(32'sd1, -32'sd1, 32'sd65536, 16'd65535, 16'd16384);
    endtask

    // receiver holds off long while poses keep coming
    task automatic test_output_backpressure();
        int i;
        pose_bus.valid <= 1'b0;
        row_hold_len = 80;
        while (!row_hold_active) @(posedge i_clk);
        for (i = 0; i < 12; i++) begin
            send_random_pose();
        end
    endtask

    // sender pauses once, after the third pose, until every queued row has come out
    task automatic test_drained_pause();
        int i;
        for (i = 0; i < 6; i++) begin
            send_random_pose();
            if (i == 2) begin
                pose_bus.valid <= 1'b0;
                wait_drained();
            end
        end
    endtask

    task automatic test_random_poses();
        int i;
        for (i = 0; i < 52; i++) begin
            send_random_pose();
        end
    endtask

    // back-to-back poses with no idling on either side
    task automatic test_full_rate();
        int i;
        idle_on = 1'b0;
        for (i = 0; i < 20; i++) begin
            send_random_pose();
        end
    endtask

    initial begin
        mismatch_count  = 0;
        quiet_cycles    = 0;
        idle_on         = 1'b1;
        row_hold_len    = 0;
        row_hold_active = 1'b0;
        build_sine_lut();
        i_rst_n              <= 1'b0;
        pose_bus.valid       <= 1'b0;
        pose_bus.pos_x       <= '0;
        pose_bus.pos_y       <= '0;
        pose_bus.pos_z       <= '0;
        pose_bus.yaw_angle   <= '0;
        pose_bus.pitch_angle <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_angle_extremes();
        test_translation_saturation();
        test_output_backpressure();
        test_drained_pause();
        test_random_poses();
        test_full_rate();

        pose_bus.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && view_rows_due.size() == 0) begin
            $display("camera_view_matrix_top_test passed");
        end else begin
            $display("camera_view_matrix_top_test failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/cvm_pkg.sv
hdl/cvm_if.sv
hdl/cvm_sincos.sv
hdl/camera_view_matrix_top.sv
sim/camera_view_matrix_top_test.sv
